// ===== hdl/fpra_pkg.sv =====
// Shared types, codes and constants for the region allocator.
package fpra_pkg;

  localparam int MaxSegments = 16;
  localparam int SizeBits    = 16;
  localparam logic [15:0] RegionReset = 16'd1024;

  localparam logic CfgIdxPolicy = 1'b0;
  localparam logic CfgIdxRegion = 1'b1;

  localparam logic [1:0] PolFirst = 2'd0;
  localparam logic [1:0] PolNext  = 2'd1;
  localparam logic [1:0] PolBest  = 2'd2;
  localparam logic [1:0] PolWorst = 2'd3;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNoFit    = 3'd1;
  localparam logic [2:0] StZeroSize = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StBadFree  = 3'd4;

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch request, clear scan state
    logic rebuild;     // reset table to one free segment
    logic scan_step;   // examine segment at scan index
    logic shift_step;  // one move of the table shift
    logic commit;      // table update, result or both
    logic split_init;  // set up shift for a split
    logic merge_init;  // enter the merge phase after a free
  } fpra_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic shift_done;
    logic need_merge;
  } fpra_sts_t;

endpackage

// ===== hdl/fit_policy_region_allocator.sv =====
// Top level of the region allocator: configuration registers, controller and datapath.
// Steps: a scan of the table (next fit scans twice), a decision, any shift moves and a commit;
// a free without error commits, shifts to merge and commits again before its result. The result
// strobe is registered at the final commit. One request at a time; the receiver cannot stall.
// Synchronous active-low reset gives one free segment of 1024 units and first fit.
module fit_policy_region_allocator #(
  parameter int MAX_SEGMENTS = fpra_pkg::MaxSegments,
  parameter int SIZE_BITS    = fpra_pkg::SizeBits
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [15:0] in_req_size,
  input  logic [15:0] in_free_offset,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_granted_offset,
  output logic [15:0] out_granted_size,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [1:0]  policy_r;
  logic        region_wr;
  fpra_pkg::fpra_cmd_t cmd;
  fpra_pkg::fpra_sts_t sts;

  // A region size write rebuilds the table straight from the write data.
  assign region_wr = cfg_wr_en && cfg_index == fpra_pkg::CfgIdxRegion;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= fpra_pkg::PolFirst;
    end else if (cfg_wr_en && cfg_index == fpra_pkg::CfgIdxPolicy) begin
      policy_r <= cfg_wdata[1:0];
    end
  end

  fpra_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .cfg_region_wr (region_wr),
    .sts           (sts),
    .cmd           (cmd),
    .busy          (busy)
  );

  fpra_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .SIZE_BITS    (SIZE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .policy             (policy_r),
    .region             (cfg_wdata),
    .in_func            (in_func),
    .in_req_size        (in_req_size),
    .in_free_offset     (in_free_offset),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_granted_offset (out_granted_offset),
    .out_granted_size   (out_granted_size)
  );

endmodule

// ===== hdl/fpra_ctrl.sv =====
// Controller state machine for the region allocator.
module fpra_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               cfg_region_wr,
  input  fpra_pkg::fpra_sts_t sts,
  output fpra_pkg::fpra_cmd_t cmd,
  output logic               busy
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_DEC   = 6'b000100,
    S_SHIFT = 6'b001000,
    S_DONE  = 6'b010000,
    S_MERGE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.rebuild = cfg_region_wr;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_DEC;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_DEC: begin
        // The datapath decides: error, direct commit or split shift; a free without error goes on to merge.
        cmd.split_init = 1'b1;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts.shift_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_DONE: begin
        cmd.commit = 1'b1;
        state_nxt = sts.need_merge ? S_MERGE : S_IDLE;
      end
      S_MERGE: begin
        cmd.merge_init = 1'b1;
        state_nxt = S_SHIFT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== hdl/fpra_dp.sv =====
// Datapath of the region allocator: segment table, scan and shift logic.
module fpra_dp #(
  parameter int MAX_SEGMENTS = fpra_pkg::MaxSegments,
  parameter int SIZE_BITS    = fpra_pkg::SizeBits
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fpra_pkg::fpra_cmd_t  cmd,
  output fpra_pkg::fpra_sts_t  sts,
  input  logic [1:0]           policy,
  input  logic [15:0]          region,
  input  logic                 in_func,
  input  logic [15:0]          in_req_size,
  input  logic [15:0]          in_free_offset,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic [15:0]          out_granted_offset,
  output logic [15:0]          out_granted_size
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int SW = SIZE_BITS;

  logic [SW-1:0] start_r [MAX_SEGMENTS];
  logic [SW-1:0] len_r   [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] used_r;
  logic [CW-1:0] count_r;
  logic [SW-1:0] last_off_r;
  logic          last_vld_r;

  logic          func_r;
  logic [SW-1:0] req_r, off_r;
  logic [1:0]    pol_r;
  logic [CW-1:0] scan_r;       // scan step number
  logic [CW-1:0] first_r;      // next fit start index
  logic          first_ok_r;   // first index found (next fit)
  logic          found_r;
  logic [IW-1:0] pick_r;
  logic [SW-1:0] pick_len_r;
  // Shift machinery: dir 1 opens a hole after pick, dir 0 closes dist_r entries at pos.
  logic          dir_r;
  logic [1:0]    dist_r;
  logic [CW-1:0] pos_r;
  logic [CW-1:0] end_r;
  logic          act_r;        // a table change is pending
  logic [2:0]    err_r;
  logic          phase2_r;     // a free has updated the table and only reports now

  logic [SW-1:0] req_in, off_in;
  assign req_in = SW'(in_req_size);
  assign off_in = SW'(in_free_offset);

  // Scan index for the current step.
  logic [CW-1:0] idx_full;
  logic [IW-1:0] idx;
  logic [CW:0]   wrap_sum;
  logic          fit_i, hit_i;

  always_comb begin
    wrap_sum = {1'b0, first_r} + {1'b0, scan_r};
    if (wrap_sum >= {1'b0, count_r}) begin
      wrap_sum = wrap_sum - {1'b0, count_r};
    end
    idx_full = (pol_r == fpra_pkg::PolNext && !func_r) ? wrap_sum[CW-1:0] : scan_r;
    idx = idx_full[IW-1:0];
    fit_i = !used_r[idx] && (len_r[idx] >= req_r);
    hit_i = (start_r[idx] == off_r);
  end

  // Next fit first pass locates the start index; then the main scan runs.
  logic first_pass;
  assign first_pass = !func_r && pol_r == fpra_pkg::PolNext && !first_ok_r;

  assign sts.scan_done = first_pass ? 1'b0 :
                         (scan_r >= count_r) || (found_r && func_r) ||
                         (found_r && !func_r && (pol_r == fpra_pkg::PolFirst ||
                                                 pol_r == fpra_pkg::PolNext));
  assign sts.shift_done = !act_r || (dir_r ? (pos_r <= end_r) : (pos_r >= end_r));
  assign sts.need_merge = func_r && (err_r == fpra_pkg::StOk) && !phase2_r;

  logic [IW-1:0] pos_i, pos_im1, pos_src;
  assign pos_i   = pos_r[IW-1:0];
  assign pos_im1 = IW'(pos_r - CW'(1));
  assign pos_src = IW'(pos_r + CW'(dist_r));

  logic [IW-1:0] pick_p1, pick_m1;
  assign pick_p1 = IW'({1'b0, pick_r} + (IW+1)'(1));
  assign pick_m1 = IW'({1'b0, pick_r} - (IW+1)'(1));

  // A freed segment absorbs free neighbours on both sides into one entry.
  logic          merge_rt, merge_lt;
  logic [IW-1:0] tgt;
  logic [1:0]    drop_n;
  logic [SW-1:0] merged_len;

  always_comb begin
    merge_rt = ({1'b0, pick_r} + (IW+1)'(1) < (IW+1)'(count_r)) && !used_r[pick_p1];
    merge_lt = (pick_r != '0) && !used_r[pick_m1];
    tgt = merge_lt ? pick_m1 : pick_r;
    drop_n = {1'b0, merge_rt} + {1'b0, merge_lt};
    merged_len = len_r[pick_r];
    if (merge_rt) begin
      merged_len = merged_len + len_r[pick_p1];
    end
    if (merge_lt) begin
      merged_len = merged_len + len_r[pick_m1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r[0] <= '0;
      len_r[0]   <= SW'(fpra_pkg::RegionReset);
      used_r     <= '0;
      count_r    <= CW'(1);
      last_off_r <= '0;
      last_vld_r <= 1'b0;
      out_valid  <= 1'b0;
      act_r      <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cmd.rebuild) begin
        start_r[0] <= '0;
        len_r[0]   <= SW'(region);
        used_r     <= '0;
        count_r    <= CW'(1);
        last_vld_r <= 1'b0;
      end
      if (cmd.capture) begin
        func_r     <= in_func;
        req_r      <= req_in;
        off_r      <= off_in;
        pol_r      <= policy;
        scan_r     <= '0;
        first_r    <= '0;
        first_ok_r <= !(policy == fpra_pkg::PolNext && last_vld_r);
        found_r    <= 1'b0;
        act_r      <= 1'b0;
        phase2_r   <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (first_pass) begin
          if (scan_r >= count_r) begin
            first_r <= '0;
            first_ok_r <= 1'b1;
            scan_r <= '0;
          end else if (start_r[idx] > last_off_r) begin
            first_r <= scan_r;
            first_ok_r <= 1'b1;
            scan_r <= '0;
          end else begin
            scan_r <= scan_r + CW'(1);
          end
        end else begin
          scan_r <= scan_r + CW'(1);
          if (func_r) begin
            if (hit_i) begin
              found_r <= 1'b1;
              pick_r  <= idx;
            end
          end else if (fit_i) begin
            if (!found_r ||
                (pol_r == fpra_pkg::PolBest && len_r[idx] < pick_len_r) ||
                (pol_r == fpra_pkg::PolWorst && len_r[idx] > pick_len_r)) begin
              found_r    <= 1'b1;
              pick_r     <= idx;
              pick_len_r <= len_r[idx];
            end
          end
        end
      end
      if (cmd.split_init) begin
        // Decide the request outcome and set up any shift.
        err_r <= fpra_pkg::StOk;
        if (!func_r) begin
          if (req_r == '0) begin
            err_r <= fpra_pkg::StZeroSize;
          end else if (!found_r) begin
            err_r <= fpra_pkg::StNoFit;
          end else if (len_r[pick_r] > req_r) begin
            if (count_r >= CW'(MAX_SEGMENTS)) begin
              err_r <= fpra_pkg::StFull;
            end else begin
              act_r <= 1'b1;
              dir_r <= 1'b1;
              pos_r <= count_r;
              end_r <= CW'({1'b0, pick_r}) + CW'(1);
            end
          end
        end else if (!found_r || !used_r[pick_r]) begin
          err_r <= fpra_pkg::StBadFree;
        end
      end
      if (cmd.shift_step) begin
        if (dir_r) begin
          start_r[pos_i] <= start_r[pos_im1];
          len_r[pos_i]   <= len_r[pos_im1];
          used_r[pos_i]  <= used_r[pos_im1];
          pos_r <= pos_r - CW'(1);
        end else begin
          start_r[pos_i] <= start_r[pos_src];
          len_r[pos_i]   <= len_r[pos_src];
          used_r[pos_i]  <= used_r[pos_src];
          pos_r <= pos_r + CW'(1);
        end
      end
      if (cmd.commit) begin
        act_r <= 1'b0;
        if (err_r != fpra_pkg::StOk) begin
          out_valid          <= 1'b1;
          out_status         <= err_r;
          out_granted_offset <= '0;
          out_granted_size   <= '0;
        end else if (!func_r) begin
          if (act_r) begin
            start_r[pick_p1] <= start_r[pick_r] + req_r;
            len_r[pick_p1]   <= len_r[pick_r] - req_r;
            used_r[pick_p1]  <= 1'b0;
            count_r          <= count_r + CW'(1);
            len_r[pick_r]    <= req_r;
          end
          used_r[pick_r] <= 1'b1;
          if (pol_r == fpra_pkg::PolNext) begin
            last_off_r <= start_r[pick_r];
            last_vld_r <= 1'b1;
          end
          out_valid          <= 1'b1;
          out_status         <= fpra_pkg::StOk;
          out_granted_offset <= 16'(start_r[pick_r]);
          out_granted_size   <= act_r ? 16'(req_r) : 16'(len_r[pick_r]);
        end else if (!phase2_r) begin
          // Free: the merged entry keeps the lowest start, and the entries
          // above the absorbed ones move down to close the gap.
          used_r[pick_r] <= 1'b0;
          len_r[tgt]     <= merged_len;
          pick_r         <= tgt;
          count_r        <= count_r - CW'(drop_n);
          act_r          <= (drop_n != 2'd0);
          dir_r          <= 1'b0;
          dist_r         <= drop_n;
          pos_r          <= CW'({1'b0, tgt}) + CW'(1);
          end_r          <= count_r - CW'(drop_n);
        end else begin
          out_valid          <= 1'b1;
          out_status         <= fpra_pkg::StOk;
          out_granted_offset <= 16'(start_r[pick_r]);
          out_granted_size   <= 16'(len_r[pick_r]);
        end
      end
      if (cmd.merge_init) begin
        phase2_r <= 1'b1;
      end
    end
  end

endmodule
